// ===== hw/rtl/bmrle_pkg.sv =====
// Shared types and constants for the run-length bitmap decoder.
`timescale 1ns / 1ps

package bmrle_pkg;

  // Result error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_ZERO    = 2'd1;
  localparam logic [1:0] ERR_OVERRUN = 2'd2;
  localparam logic [1:0] ERR_RECT    = 2'd3;

  // Header is ten bytes; the count value of its last byte
  localparam logic [3:0] HDR_LAST = 4'd9;

  // Configuration register indexes
  localparam logic REG_BYTE_ORDER = 1'b0;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_FINISH,
    ST_COUNT,
    ST_WORD_A,
    ST_WORD_B,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_HALT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic       hdr_byte;   // take a header byte
    logic       finish;     // close the header, clear the line store
    logic       count_byte; // load a run count
    logic       word_a;     // hold first data byte
    logic       word_b;     // assemble data word
    logic       mem_rd;     // read line store at current column
    logic       emit;       // XOR, write back, emit, advance
    logic       err_load;   // emit an error result
    logic [1:0] err_code;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hdr_last;
    logic hdr_bad;
    logic hdr_empty;
    logic cnt_zero;
    logic cnt_over;
    logic run_last;
    logic run_repeat;
    logic img_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/bmrle_ctrl.sv =====
// Sequencer for header, run counts, data bytes and word emission.
`timescale 1ns / 1ps

module bmrle_ctrl import bmrle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t stat,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state, state_next;
  logic        accept;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HEADER;
    end else begin
      state <= state_next;
    end
  end

  assign accept = in_valid && !in_stall;

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.err_code = ERR_NONE;
    in_stall     = 1'b0;
    unique case (state)
      ST_HEADER: begin
        if (accept) begin
          cmd.hdr_byte = 1'b1;
          if (stat.hdr_last) state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        in_stall = 1'b1;
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          if (stat.hdr_bad) begin
            cmd.err_load = 1'b1;
            cmd.err_code = ERR_RECT;
            state_next   = ST_HALT;
          end else if (stat.hdr_empty) begin
            state_next = ST_HEADER;
          end else begin
            state_next = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        // hold input until an error result could be placed
        in_stall = !stat.out_free;
        if (accept) begin
          if (stat.cnt_zero) begin
            cmd.err_load = 1'b1;
            cmd.err_code = ERR_ZERO;
            state_next   = ST_HALT;
          end else if (stat.cnt_over) begin
            cmd.err_load = 1'b1;
            cmd.err_code = ERR_OVERRUN;
            state_next   = ST_HALT;
          end else begin
            cmd.count_byte = 1'b1;
            state_next     = ST_WORD_A;
          end
        end
      end
      ST_WORD_A: begin
        if (accept) begin
          cmd.word_a = 1'b1;
          state_next = ST_WORD_B;
        end
      end
      ST_WORD_B: begin
        if (accept) begin
          cmd.word_b = 1'b1;
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        in_stall   = 1'b1;
        cmd.mem_rd = 1'b1;
        state_next = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        in_stall = 1'b1;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          priority if (stat.img_last) begin
            state_next = ST_HEADER;
          end else if (stat.run_last) begin
            state_next = ST_COUNT;
          end else if (stat.run_repeat) begin
            state_next = ST_EMIT_RD;
          end else begin
            state_next = ST_WORD_A;
          end
        end
      end
      ST_HALT: begin
        // drop every byte until reset
      end
      default: begin
        state_next = ST_HEADER;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bmrle_datapath.sv =====
// Header registers, run counters, line store and result register.
`timescale 1ns / 1ps

module bmrle_datapath import bmrle_pkg::*; #(
  parameter int RASTER_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        byte_order,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  stat,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [15:0] pixel_word,
  output logic [15:0] row_index,
  output logic [5:0]  column_index,
  output logic        last_in_row,
  output logic        last_in_image,
  output logic [1:0]  error_code
);

  localparam int COL_W = (RASTER_WORDS > 1) ? $clog2(RASTER_WORDS) : 1;
  localparam int WPR_W = $clog2(RASTER_WORDS + 1);

  logic [3:0]        hdr_count;
  logic [7:0]        held_low_byte;
  logic [15:0]       header_words [4];
  logic [15:0]       rows_total;
  logic [WPR_W-1:0]  words_per_row;
  logic [15:0]       current_row;
  logic [COL_W-1:0]  current_column;
  logic [6:0]        run_words_left;
  logic              run_is_repeat;
  logic [15:0]       data_word;

  logic [15:0]       line_store [RASTER_WORDS];
  logic [RASTER_WORDS-1:0] line_valid;
  logic [15:0]       rd_data;
  logic              rd_valid;

  // Header geometry
  logic [16:0] height, width, width_round;
  logic [12:0] nwords;
  logic [1:0]  hdr_index;

  always_comb begin
    height      = {header_words[3][15], header_words[3]} -
                  {header_words[1][15], header_words[1]};
    width       = {header_words[2][15], header_words[2]} -
                  {header_words[0][15], header_words[0]};
    width_round = {1'b0, width[15:0]} + 17'd15;
    nwords      = width_round[16:4];
    hdr_index   = 2'(hdr_count[3:1] - 3'd1);
  end

  // Emission terms
  logic [6:0]       run_n;
  logic [7:0]       run_end;
  logic [WPR_W:0]   col_plus;
  logic [16:0]      row_plus;
  logic             lrow, limg;
  logic [15:0]      xor_word;

  always_comb begin
    run_n    = data_byte[6:0];
    run_end  = 8'(run_n) + 8'(current_column);
    col_plus = (WPR_W + 1)'(current_column) + 1'b1;
    row_plus = {1'b0, current_row} + 17'd1;
    lrow     = col_plus >= (WPR_W + 1)'(words_per_row);
    limg     = lrow && (row_plus >= {1'b0, rows_total});
    xor_word = data_word ^ (rd_valid ? rd_data : 16'h0000);
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    stat.hdr_last   = hdr_count == HDR_LAST;
    stat.hdr_bad    = height[16] || width[16] || (nwords > 13'(RASTER_WORDS));
    stat.hdr_empty  = (height == 17'd0) || (nwords == 13'd0);
    stat.cnt_zero   = run_n == 7'd0;
    stat.cnt_over   = run_end > 8'(words_per_row);
    stat.run_last   = run_words_left == 7'd1;
    stat.run_repeat = run_is_repeat;
    stat.img_last   = limg;
    stat.out_free   = out_free;
  end

  // Header capture and image setup
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_count      <= '0;
      held_low_byte  <= '0;
      rows_total     <= '0;
      words_per_row  <= '0;
      current_row    <= '0;
      current_column <= '0;
      run_words_left <= '0;
      run_is_repeat  <= 1'b0;
    end else begin
      if (cmd.hdr_byte) begin
        hdr_count <= hdr_count + 4'd1;
        if (hdr_count[0]) begin
          if (hdr_count >= 4'd3) header_words[hdr_index] <= {data_byte, held_low_byte};
        end else begin
          held_low_byte <= data_byte;
        end
      end
      if (cmd.finish) begin
        hdr_count      <= '0;
        current_row    <= '0;
        current_column <= '0;
        run_words_left <= '0;
        run_is_repeat  <= 1'b0;
        if (!stat.hdr_bad) begin
          rows_total    <= height[15:0];
          words_per_row <= WPR_W'(nwords);
        end
      end
      if (cmd.count_byte) begin
        run_is_repeat  <= data_byte[7];
        run_words_left <= run_n;
      end
      if (cmd.word_a) held_low_byte <= data_byte;
      if (cmd.emit) begin
        run_words_left <= run_words_left - 7'd1;
        if (lrow) begin
          current_column <= '0;
          current_row    <= current_row + 16'd1;
          if (limg) hdr_count <= '0;
        end else begin
          current_column <= COL_W'(col_plus);
        end
      end
    end
  end

  // Assemble data word
  always_ff @(posedge clk) begin
    if (cmd.word_b) begin
      data_word <= byte_order ? {held_low_byte, data_byte} : {data_byte, held_low_byte};
    end
  end

  // Line store: registered read, write back of the XOR result
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rd_data <= line_store[current_column];
    if (cmd.emit) line_store[current_column] <= xor_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (cmd.mem_rd) rd_valid <= line_valid[current_column];
      if (cmd.finish) begin
        line_valid <= '0;
      end else if (cmd.emit) begin
        line_valid[current_column] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.err_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_word    <= xor_word;
      row_index     <= current_row;
      column_index  <= 6'(current_column);
      last_in_row   <= lrow;
      last_in_image <= limg;
      error_code    <= ERR_NONE;
    end else if (cmd.err_load) begin
      pixel_word    <= 16'h0000;
      row_index     <= cmd.finish ? 16'h0000 : current_row;
      column_index  <= cmd.finish ? 6'd0 : 6'(current_column);
      last_in_row   <= 1'b0;
      last_in_image <= 1'b1;
      error_code    <= cmd.err_code;
    end
  end

endmodule

// ===== hw/rtl/bitmap_rle_line_xor_decoder_top.sv =====
// Top level of the run-length bitmap decoder with line XOR.
`timescale 1ns / 1ps

// Takes a bitmap file one byte per transaction: a ten-byte header (skipped
// word, origin x/y, corner x/y, little-endian), then per row count bytes
// with literal or repeated 16-bit data words. Each word is XORed with the
// same column of the previous row and emitted with its row, column and
// end-of-row/end-of-image marks; errors give one result with last_in_image
// set, after which input bytes are taken and dropped until reset. Steps:
// header bytes, count bytes and first data bytes are taken as they arrive,
// closing the header is its own step, and each emitted word is a line
// store read, then XOR and write back through the single line store port,
// input held meanwhile; a repeat run of n words repeats these two steps
// per word after its data bytes. Result side stalls hold the header
// close, count bytes and emission. The line store is cleared at the end
// of each header through per-entry valid bits; no clearing pass.
// Register 0 at byte address 0, bit 0: data word byte order (1 high first).
module bitmap_rle_line_xor_decoder_top import bmrle_pkg::*; #(
  parameter int RASTER_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pixel_word,
  output logic [15:0] row_index,
  output logic [5:0]  column_index,
  output logic        last_in_row,
  output logic        last_in_image,
  output logic [1:0]  error_code
);

  logic       data_byte_order;
  ctrl_cmd_t  cmd;
  dp_status_t stat;

  assign pready = 1'b1;

  // Configuration register write
  always_ff @(posedge clk) begin
    if (rst) begin
      data_byte_order <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BYTE_ORDER)) begin
      data_byte_order <= pwdata[0];
    end
  end

  // Register read
  always_comb begin
    prdata = 32'h0;
    if (paddr[2] == REG_BYTE_ORDER) prdata = {31'h0, data_byte_order};
  end

  bmrle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmrle_datapath #(
    .RASTER_WORDS (RASTER_WORDS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (data_byte),
    .byte_order    (data_byte_order),
    .cmd           (cmd),
    .stat          (stat),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .pixel_word    (pixel_word),
    .row_index     (row_index),
    .column_index  (column_index),
    .last_in_row   (last_in_row),
    .last_in_image (last_in_image),
    .error_code    (error_code)
  );

endmodule
